/* hw/rtl/quoted_field_tokenizer_defines.svh */
// Assertion macros for the quoted field tokenizer checker
`ifndef QUOTED_FIELD_TOKENIZER_DEFINES_SVH
`define QUOTED_FIELD_TOKENIZER_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent
`define QFT_CHECK(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequent in the cycle after its antecedent
`define QFT_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/qft_pkg.sv */
// Shared types, constants and helpers of the quoted field tokenizer
package qft_pkg;

	// Character set lanes
	localparam int SEPARATOR_SLOTS = 4;
	localparam int SPACE_SLOTS     = 4;
	localparam int LANES           = 4;

	// Results per request and queue sizing
	localparam int MAX_RES = 4;
	localparam int RCNT_W  = $clog2(MAX_RES + 1);
	localparam int RIDX_W  = $clog2(MAX_RES);
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	// Special bytes
	localparam logic [7:0] CH_ESC     = 8'h5C;
	localparam logic [7:0] QUOTE_CHAR = 8'h22;

	// Configuration register indexes
	localparam logic [1:0] REG_SEP_CHARS   = 2'd0;
	localparam logic [1:0] REG_SEP_COUNT   = 2'd1;
	localparam logic [1:0] REG_SPACE_CHARS = 2'd2;
	localparam logic [1:0] REG_SPACE_COUNT = 2'd3;

	// Command codes
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_END  = 1'b1;

	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_END  = 2'd1,
		KIND_DONE = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} res_t;

	// All results caused by one request
	typedef struct packed {
		logic [RCNT_W-1:0]       count;
		res_t [MAX_RES-1:0]      res;
	} bundle_t;

	// Append one result to a bundle; non-byte results carry a zero byte
	function automatic bundle_t bundle_add(bundle_t b, kind_t k, logic [7:0] d);
		bundle_t r;
		r = b;
		if (b.count < RCNT_W'(MAX_RES)) begin
			r.res[b.count[RIDX_W-1:0]].kind = k;
			r.res[b.count[RIDX_W-1:0]].data = (k == KIND_BYTE) ? d : 8'd0;
			r.count = b.count + 1'b1;
		end
		return r;
	endfunction

endpackage

/* hw/rtl/qft_front.sv */
// Front end: configuration, byte classing, parse state machine, result bundling
module qft_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic             command,
	input  logic [7:0]       char_in,
	input  logic             q_full,
	output logic             q_push,
	output qft_pkg::bundle_t q_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [31:0]      cfg_data
);
	import qft_pkg::*;

	typedef enum logic [1:0] {
		MODE_START    = 2'd0,
		MODE_QUOTED   = 2'd1,
		MODE_UNQUOTED = 2'd2,
		MODE_FINISHED = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CLS_QUOTE = 2'd0,
		CLS_SPACE = 2'd1,
		CLS_SEP   = 2'd2,
		CLS_OTHER = 2'd3
	} cls_t;

	typedef struct packed {
		mode_t mode;
		logic  e_end;
		logic  e_byte;
	} adv_t;

	mode_t       mode_q;
	logic        esc_q;
	logic [31:0] sep_chars_q;
	logic [2:0]  sep_count_q;
	logic [31:0] space_chars_q;
	logic [2:0]  space_count_q;

	logic        accept;
	logic        esc_quote;
	logic [7:0]  a_char;
	adv_t        adv_a;
	adv_t        adv_b;
	mode_t       mode_mid;
	mode_t       mode_nx;
	logic        use_b;
	cls_t        cls_b;
	bundle_t     bnd;

	function automatic logic in_set(logic [7:0] c, logic [31:0] chars, logic [2:0] count,
			int slots);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < LANES; i++) begin
			if (i < slots && count > 3'(i) && chars[8*i +: 8] == c)
				hit = 1'b1;
		end
		return hit;
	endfunction

	function automatic cls_t classify(logic [7:0] c, logic [31:0] sp_chars,
			logic [2:0] sp_count, logic [31:0] sc_chars, logic [2:0] sc_count);
		cls_t t;
		if (c == QUOTE_CHAR)
			t = CLS_QUOTE;
		else if (c == CH_ESC)
			t = CLS_OTHER;
		else if (in_set(c, sp_chars, sp_count, SPACE_SLOTS))
			t = CLS_SPACE;
		else if (in_set(c, sc_chars, sc_count, SEPARATOR_SLOTS))
			t = CLS_SEP;
		else
			t = CLS_OTHER;
		return t;
	endfunction

	// One parse step: next mode, and whether a field end and/or the byte goes out
	function automatic adv_t advance(mode_t m, cls_t t);
		adv_t a;
		a.mode   = m;
		a.e_end  = 1'b0;
		a.e_byte = 1'b0;
		unique case (m)
			MODE_START: begin
				if (t == CLS_QUOTE) begin
					a.mode = MODE_QUOTED;
				end else if (t == CLS_SEP) begin
					a.e_end = 1'b1;
				end else if (t == CLS_OTHER) begin
					a.e_byte = 1'b1;
					a.mode   = MODE_UNQUOTED;
				end
			end
			MODE_QUOTED: begin
				if (t == CLS_QUOTE)
					a.mode = MODE_FINISHED;
				else
					a.e_byte = 1'b1;
			end
			MODE_UNQUOTED: begin
				if (t == CLS_QUOTE) begin
					a.e_end = 1'b1;
					a.mode  = MODE_QUOTED;
				end else if (t == CLS_SPACE) begin
					a.mode = MODE_FINISHED;
				end else if (t == CLS_SEP) begin
					a.e_end = 1'b1;
					a.mode  = MODE_START;
				end else begin
					a.e_byte = 1'b1;
				end
			end
			MODE_FINISHED: begin
				if (t == CLS_QUOTE) begin
					a.e_end = 1'b1;
					a.mode  = MODE_QUOTED;
				end else if (t == CLS_SEP) begin
					a.e_end = 1'b1;
					a.mode  = MODE_START;
				end else if (t == CLS_OTHER) begin
					a.e_end  = 1'b1;
					a.e_byte = 1'b1;
					a.mode   = MODE_UNQUOTED;
				end
			end
			default: a.mode = MODE_START;
		endcase
		return a;
	endfunction

	assign accept    = push && !q_full;
	assign cfg_ready = 1'b1;

	// Resolve a pending backslash: literal quote before a quote, else literal backslash
	assign esc_quote = esc_q && command == CMD_BYTE && char_in == QUOTE_CHAR;
	assign a_char    = (command == CMD_BYTE && char_in == QUOTE_CHAR) ? QUOTE_CHAR : CH_ESC;
	assign adv_a     = advance(mode_q, CLS_OTHER);
	assign mode_mid  = esc_q ? adv_a.mode : mode_q;

	// Handle the new byte itself unless it was consumed or starts an escape
	assign cls_b = classify(char_in, space_chars_q, space_count_q, sep_chars_q, sep_count_q);
	assign adv_b = advance(mode_mid, cls_b);
	assign use_b = command == CMD_BYTE && !esc_quote && char_in != CH_ESC;

	// Collect results of this request in order
	always_comb begin
		bnd = '0;
		if (esc_q) begin
			if (adv_a.e_end)
				bnd = bundle_add(bnd, KIND_END, 8'd0);
			if (adv_a.e_byte)
				bnd = bundle_add(bnd, KIND_BYTE, a_char);
		end
		if (use_b) begin
			if (adv_b.e_end)
				bnd = bundle_add(bnd, KIND_END, 8'd0);
			if (adv_b.e_byte)
				bnd = bundle_add(bnd, KIND_BYTE, char_in);
		end
		if (command == CMD_END) begin
			if (mode_mid != MODE_START)
				bnd = bundle_add(bnd, KIND_END, 8'd0);
			bnd = bundle_add(bnd, KIND_DONE, 8'd0);
		end
	end

	assign mode_nx = (command == CMD_END) ? MODE_START : (use_b ? adv_b.mode : mode_mid);
	assign q_push  = accept && bnd.count != '0;
	assign q_data  = bnd;

	// Hold parse state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_START;
			esc_q         <= 1'b0;
			sep_chars_q   <= 32'd44;
			sep_count_q   <= 3'd1;
			space_chars_q <= 32'd2336;
			space_count_q <= 3'd2;
		end else begin
			if (accept) begin
				mode_q <= mode_nx;
				esc_q  <= command == CMD_BYTE && char_in == CH_ESC;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_SEP_CHARS:   sep_chars_q   <= cfg_data;
					REG_SEP_COUNT:   sep_count_q   <= cfg_data[2:0];
					REG_SPACE_CHARS: space_chars_q <= cfg_data;
					REG_SPACE_COUNT: space_count_q <= cfg_data[2:0];
					default:         sep_chars_q   <= sep_chars_q;
				endcase
			end
		end
	end

endmodule

/* hw/rtl/qft_fifo.sv */
// Short queue of result bundles between front and back
module qft_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  qft_pkg::bundle_t wr_data,
	output logic             full,
	input  logic             rd_en,
	output qft_pkg::bundle_t rd_data,
	output logic             empty
);
	import qft_pkg::*;

	bundle_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_wr;
	logic              do_rd;

	assign full    = cnt_q == QCNT_W'(QDEPTH);
	assign empty   = cnt_q == '0;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Store a bundle
	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

/* hw/rtl/qft_back.sv */
// Back end: serialize each bundle into single results on the output queue ports
module qft_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  qft_pkg::bundle_t q_data,
	output logic             q_pop,
	output logic             empty,
	input  logic             pop,
	output logic [1:0]       result_kind,
	output logic [7:0]       field_byte,
	output logic             run_last
);
	import qft_pkg::*;

	bundle_t           cur_q;
	logic [RIDX_W-1:0] idx_q;
	logic              valid_q;
	logic              last;
	logic              take;
	res_t              cur;

	assign last  = idx_q == RIDX_W'(cur_q.count - 1'b1);
	assign take  = !valid_q || (pop && last);
	assign q_pop = take && !q_empty;

	// Load a new bundle
	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_data;
	end

	// Step through the results of the held bundle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (pop && valid_q) begin
			if (last)
				valid_q <= 1'b0;
			else
				idx_q <= idx_q + 1'b1;
		end
	end

	assign cur         = cur_q.res[idx_q];
	assign empty       = !valid_q;
	assign result_kind = cur.kind;
	assign field_byte  = cur.data;
	assign run_last    = last;

endmodule

/* hw/rtl/quoted_field_tokenizer.sv */
// A byte accepted goes into the queue, then into the back end's held bundle, before
// its first result is on the ports. Throughput: one byte per cycle while pop is held
// and each byte yields at most one result; the port drains one result per cycle, so
// requests of two to four results fill the queue; full rises at four bundles.
// Reset (arst_n low, asynchronous): parser to start, no pending backslash,
// queue and output empty, registers to separator comma and spaces space and tab.
module quoted_field_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        command,
	input  logic [7:0]  char_in,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  result_kind,
	output logic [7:0]  field_byte,
	output logic        run_last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import qft_pkg::*;

	logic    q_push;
	bundle_t q_wr_data;
	logic    q_full;
	logic    q_pop;
	bundle_t q_rd_data;
	logic    q_empty;

	assign full = q_full;

	// Classify and parse each request
	qft_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.command   (command),
		.char_in   (char_in),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_wr_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Decouple front and back
	qft_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wr_data),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_rd_data),
		.empty   (q_empty)
	);

	// Deliver results one at a time
	qft_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_data      (q_rd_data),
		.q_pop       (q_pop),
		.empty       (empty),
		.pop         (pop),
		.result_kind (result_kind),
		.field_byte  (field_byte),
		.run_last    (run_last)
	);

endmodule

/* hw/rtl/qft_checker.sv */
// Port-level checker for the quoted field tokenizer, with its bind
`include "quoted_field_tokenizer_defines.svh"

module qft_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [1:0] result_kind,
	input logic [7:0] field_byte,
	input logic       run_last
);
	import qft_pkg::*;

	// A waiting result holds until popped
	`QFT_CHECK_NEXT(a_hold, !empty && !pop, !empty && $stable({result_kind, field_byte, run_last}), "result changed while waiting")

	// The done mark always closes the results of its request
	`QFT_CHECK(a_done_last, !empty && result_kind == KIND_DONE, run_last, "done mark not last")

	// Field ends and done marks carry a zero byte
	`QFT_CHECK(a_zero_byte, !empty && result_kind != KIND_BYTE, field_byte == 8'd0, "nonzero byte on a mark")

endmodule

bind quoted_field_tokenizer qft_checker u_qft_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.empty       (empty),
	.pop         (pop),
	.result_kind (result_kind),
	.field_byte  (field_byte),
	.run_last    (run_last)
);

/* tb/quoted_field_tokenizer_checker.sv */
// Checker for the quoted field tokenizer: tracks the parser state and compares every result
`timescale 1ns / 100ps

module quoted_field_tokenizer_checker
	import qft_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic        command,
	input  logic [7:0]  char_in,
	input  logic        empty,
	input  logic        pop,
	input  logic [1:0]  result_kind,
	input  logic [7:0]  field_byte,
	input  logic        run_last,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          pending_count,
	output int          requests_seen,
	output int          results_seen,
	output int          strings_seen
);

	typedef enum logic [1:0] {
		MODE_START,
		MODE_QUOTED,
		MODE_UNQUOTED,
		MODE_FINISHED
	} mode_t;

	typedef enum logic [1:0] {
		CLS_QUOTE,
		CLS_SPACE,
		CLS_SEP,
		CLS_OTHER
	} class_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       last;
	} token_t;

	// Parser state and register copies
	mode_t       mode;
	logic        esc_pending;
	logic [31:0] sep_chars;
	logic [2:0]  sep_count;
	logic [31:0] space_chars;
	logic [2:0]  space_count;

	token_t step_tokens[$];
	token_t expected_tokens[$];
	int     fails;
	int     requests;
	int     results;
	int     strings;

	// Match a byte against the lanes in use of a character set
	function automatic bit char_in_set(logic [7:0] c, logic [31:0] chars, logic [2:0] count,
			int slots);
		int lanes;
		lanes = int'(count);
		if (lanes > slots)
			lanes = slots;
		if (lanes > LANES)
			lanes = LANES;
		for (int i = 0; i < lanes; i++)
			if (chars[8*i +: 8] == c)
				return 1'b1;
		return 1'b0;
	endfunction

	// Quote and backslash win, then spaces, then separators
	function automatic class_t classify_char(logic [7:0] c);
		if (c == QUOTE_CHAR)
			return CLS_QUOTE;
		if (c == CH_ESC)
			return CLS_OTHER;
		if (char_in_set(c, space_chars, space_count, SPACE_SLOTS))
			return CLS_SPACE;
		if (char_in_set(c, sep_chars, sep_count, SEPARATOR_SLOTS))
			return CLS_SEP;
		return CLS_OTHER;
	endfunction

	function automatic void add_token(kind_t k, logic [7:0] d);
		token_t t;
		t.kind = k;
		t.data = (k == KIND_BYTE) ? d : 8'd0;
		t.last = 1'b0;
		step_tokens = {step_tokens, t};
	endfunction

	// Advance the field state machine by one classed byte
	function automatic void advance_mode(logic [7:0] c, class_t cls);
		case (mode)
			MODE_START: begin
				if (cls == CLS_QUOTE) begin
					mode = MODE_QUOTED;
				end else if (cls == CLS_SEP) begin
					add_token(KIND_END, 8'd0);
				end else if (cls == CLS_OTHER) begin
					add_token(KIND_BYTE, c);
					mode = MODE_UNQUOTED;
				end
			end
			MODE_QUOTED: begin
				if (cls == CLS_QUOTE)
					mode = MODE_FINISHED;
				else
					add_token(KIND_BYTE, c);
			end
			MODE_UNQUOTED: begin
				if (cls == CLS_QUOTE) begin
					add_token(KIND_END, 8'd0);
					mode = MODE_QUOTED;
				end else if (cls == CLS_SPACE) begin
					mode = MODE_FINISHED;
				end else if (cls == CLS_SEP) begin
					add_token(KIND_END, 8'd0);
					mode = MODE_START;
				end else begin
					add_token(KIND_BYTE, c);
				end
			end
			default: begin
				if (cls == CLS_QUOTE) begin
					add_token(KIND_END, 8'd0);
					mode = MODE_QUOTED;
				end else if (cls == CLS_SEP) begin
					add_token(KIND_END, 8'd0);
					mode = MODE_START;
				end else if (cls == CLS_OTHER) begin
					add_token(KIND_END, 8'd0);
					add_token(KIND_BYTE, c);
					mode = MODE_UNQUOTED;
				end
			end
		endcase
	endfunction

	// Work out the results of one request and queue them
	function automatic void predict_request(logic cmd, logic [7:0] c);
		bit consumed;
		token_t t;
		step_tokens.delete();
		consumed = 1'b0;
		if (cmd == CMD_BYTE) begin
			// a held backslash either escapes this quote or leaves as a plain byte
			if (esc_pending) begin
				esc_pending = 1'b0;
				if (c == QUOTE_CHAR) begin
					advance_mode(QUOTE_CHAR, CLS_OTHER);
					consumed = 1'b1;
				end else begin
					advance_mode(CH_ESC, CLS_OTHER);
				end
			end
			if (!consumed) begin
				if (c == CH_ESC)
					esc_pending = 1'b1;
				else
					advance_mode(c, classify_char(c));
			end
		end else begin
			// flush the backslash and the open field, then mark the string done
			if (esc_pending)
				advance_mode(CH_ESC, CLS_OTHER);
			if (mode != MODE_START)
				add_token(KIND_END, 8'd0);
			add_token(KIND_DONE, 8'd0);
			mode = MODE_START;
			esc_pending = 1'b0;
		end
		while (step_tokens.size() > MAX_RES)
			void'(step_tokens.pop_back());
		for (int i = 0; i < step_tokens.size(); i++) begin
			t = step_tokens[i];
			t.last = (i == step_tokens.size() - 1);
			expected_tokens = {expected_tokens, t};
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		token_t want;
		if (!arst_n) begin
			mode = MODE_START;
			esc_pending = 1'b0;
			sep_chars = 32'd44;
			sep_count = 3'd1;
			space_chars = 32'd2336;
			space_count = 3'd2;
			expected_tokens.delete();
			fails = 0;
			requests = 0;
			results = 0;
			strings = 0;
		end else begin
			// Compare the result leaving the block
			if (pop && !empty) begin
				results++;
				if (expected_tokens.size() == 0) begin
					$error("unexpected result: result_kind %0d field_byte 0x%02h run_last %0b",
						result_kind, field_byte, run_last);
					fails++;
				end else begin
					want = expected_tokens.pop_front();
					if (result_kind !== want.kind) begin
						$error("result_kind: expected %0d, actual %0d", want.kind, result_kind);
						fails++;
					end
					if (field_byte !== want.data) begin
						$error("field_byte: expected 0x%02h, actual 0x%02h", want.data, field_byte);
						fails++;
					end
					if (run_last !== want.last) begin
						$error("run_last: expected %0b, actual %0b", want.last, run_last);
						fails++;
					end
				end
			end

			// Track register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SEP_CHARS:   sep_chars = cfg_data;
					REG_SEP_COUNT:   sep_count = cfg_data[2:0];
					REG_SPACE_CHARS: space_chars = cfg_data;
					REG_SPACE_COUNT: space_count = cfg_data[2:0];
					default: ;
				endcase
			end

			// Predict an accepted request
			if (push && !full) begin
				requests++;
				if (command == CMD_END)
					strings++;
				predict_request(command, char_in);
			end
		end
		fail_count <= fails;
		pending_count <= expected_tokens.size();
		requests_seen <= requests;
		results_seen <= results;
		strings_seen <= strings;
	end

endmodule

/* tb/quoted_field_tokenizer_tb.sv */
// Testbench top for the quoted field tokenizer: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module quoted_field_tokenizer_tb;
	import qft_pkg::*;

	localparam int CYCLE_LIMIT    = 200000;
	localparam int PHASE_REQUESTS = 14;
	localparam int HOLD_CYCLES    = 60;
	localparam int SETTLE_CYCLES  = 12;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic        command;
	logic [7:0]  char_in;
	logic        empty;
	logic        pop;
	logic [1:0]  result_kind;
	logic [7:0]  field_byte;
	logic        run_last;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	int fail_count;
	int pending_count;
	int requests_seen;
	int results_seen;
	int strings_seen;

	int          cycle_count;
	int          settings_used;
	int          requests_sent;
	int          hold_asked;
	bit          steady_send;
	bit          steady_recv;
	logic [7:0]  stim_sep[LANES];
	int          stim_sep_n;
	logic [7:0]  stim_space[LANES];
	int          stim_space_n;

	quoted_field_tokenizer dut (.*);

	quoted_field_tokenizer_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort a hung run
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[quoted_field_tokenizer] ERROR");
		$finish;
	end

	// Drain results, idling at random and holding off on request
	initial begin
		int served;
		served = 0;
		forever begin
			@(posedge clk);
			if (hold_asked > served) begin
				served++;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			pop <= steady_recv || ($urandom_range(99) >= 37);
		end
	end

	// Offer one request and hold it until accepted
	task automatic send_request(logic cmd, logic [7:0] c);
		// idle at random before offering
		while (!steady_send && $urandom_range(99) < 37) begin
			push <= 1'b0;
			command <= 1'($urandom_range(1));
			char_in <= 8'($urandom_range(255));
			@(posedge clk);
		end
		push <= 1'b1;
		command <= cmd;
		char_in <= c;
		do @(posedge clk); while (full);
		requests_sent++;
	endtask

	task automatic send_byte(logic [7:0] c);
		send_request(CMD_BYTE, c);
	endtask

	task automatic send_end();
		send_request(CMD_END, 8'($urandom_range(255)));
	endtask

	task automatic write_reg(logic [1:0] index, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Load all four registers and keep a copy for shaping the stimulus
	task automatic apply_setting(logic [31:0] sep, logic [2:0] sep_n, logic [31:0] sp,
			logic [2:0] sp_n);
		write_reg(REG_SEP_CHARS, sep);
		write_reg(REG_SEP_COUNT, 32'(sep_n));
		write_reg(REG_SPACE_CHARS, sp);
		write_reg(REG_SPACE_COUNT, 32'(sp_n));
		cfg_valid <= 1'b0;
		for (int i = 0; i < LANES; i++) begin
			stim_sep[i] = sep[8*i +: 8];
			stim_space[i] = sp[8*i +: 8];
		end
		stim_sep_n = (int'(sep_n) > LANES) ? LANES : int'(sep_n);
		stim_space_n = (int'(sp_n) > LANES) ? LANES : int'(sp_n);
		settings_used++;
	endtask

	// Stop offering and wait until every expected result has left the block
	task automatic drain_results();
		push <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_letter();
		return "a" + 8'($urandom_range(25));
	endfunction

	function automatic logic [7:0] pick_sep();
		if (stim_sep_n == 0)
			return ",";
		return stim_sep[$urandom_range(stim_sep_n - 1)];
	endfunction

	function automatic logic [7:0] pick_space();
		if (stim_space_n == 0)
			return " ";
		return stim_space[$urandom_range(stim_space_n - 1)];
	endfunction

	// Field content: mostly letters, some set members, a few raw bytes
	function automatic logic [7:0] pick_content();
		int r;
		r = $urandom_range(9);
		if (r < 6)
			return pick_letter();
		if (r == 6)
			return pick_space();
		if (r == 7)
			return pick_sep();
		return 8'($urandom_range(255));
	endfunction

	// Any byte, weighted toward the special ones
	function automatic logic [7:0] pick_noise();
		int r;
		r = $urandom_range(7);
		if (r < 2)
			return QUOTE_CHAR;
		if (r == 2)
			return CH_ESC;
		if (r == 3)
			return pick_sep();
		if (r == 4)
			return pick_space();
		return 8'($urandom_range(255));
	endfunction

	// Send a well-formed string of quoted and plain fields with random content
	task automatic send_string();
		int  fields;
		bit  quoted;
		fields = $urandom_range(1, 4);
		for (int f = 0; f < fields; f++) begin
			quoted = $urandom_range(1);
			if ($urandom_range(3) == 0)
				send_byte(pick_space());
			if (quoted)
				send_byte(QUOTE_CHAR);
			repeat ($urandom_range(0, 4)) begin
				if ($urandom_range(5) == 0) begin
					send_byte(CH_ESC);
					send_byte(quoted ? QUOTE_CHAR : pick_content());
				end else begin
					send_byte(pick_content());
				end
			end
			if (quoted)
				send_byte(QUOTE_CHAR);
			if ($urandom_range(3) == 0)
				send_byte(pick_space());
			if (f < fields - 1)
				send_byte(pick_sep());
		end
		send_end();
	endtask

	// Mostly well-formed strings, the rest loose bytes and early ends
	task automatic run_random_phase();
		int first;
		first = requests_sent;
		while (requests_sent - first < PHASE_REQUESTS) begin
			if ($urandom_range(4) == 0) begin
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(3) == 0)
						send_end();
					else
						send_byte(pick_noise());
				end
			end else begin
				send_string();
			end
		end
	endtask

	// Walk every state, each escape case, both ends of the byte range and the empty string
	task automatic run_directed();
		send_end();
		send_byte("a");
		send_byte(",");
		send_byte(",");
		send_byte(" ");
		send_byte(QUOTE_CHAR);
		send_byte(",");
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(CH_ESC);
		send_byte(QUOTE_CHAR);
		send_byte(QUOTE_CHAR);
		send_byte(" ");
		send_byte(",");
		send_byte(QUOTE_CHAR);
		send_byte(QUOTE_CHAR);
		send_byte(QUOTE_CHAR);
		send_byte(QUOTE_CHAR);
		send_byte("b");
		send_byte(" ");
		send_byte(CH_ESC);
		send_byte("c");
		send_byte(QUOTE_CHAR);
		send_byte(CH_ESC);
		send_end();
		send_byte("x");
		send_byte(" ");
		send_byte(CH_ESC);
		send_end();
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		command = CMD_BYTE;
		char_in = 8'd0;
		pop = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_SEP_CHARS;
		cfg_data = 32'd0;
		steady_send = 1'b0;
		steady_recv = 1'b0;
		hold_asked = 0;
		settings_used = 0;
		requests_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset values, written back explicitly
		apply_setting(32'd44, 3'd1, 32'd2336, 3'd2);
		run_directed();
		drain_results();

		// Four separators, no spaces; stall the drain so the block backs up
		apply_setting({":", "|", ";", ","}, 3'd4, 32'h0000_0920, 3'd0);
		steady_send = 1'b1;
		hold_asked++;
		run_random_phase();
		steady_send = 1'b0;
		drain_results();

		// No separators, four spaces; run with no idling on either side
		apply_setting(32'h0000_0000, 3'd0, {".", "_", "\t", " "}, 3'd4);
		steady_send = 1'b1;
		steady_recv = 1'b1;
		run_random_phase();
		steady_send = 1'b0;
		steady_recv = 1'b0;
		drain_results();

		// All-ones separator lanes, all-zero space lanes
		apply_setting(32'hFFFF_FFFF, 3'd4, 32'h0000_0000, 3'd4);
		run_random_phase();
		drain_results();

		// Quote and backslash in the sets, comma in both sets
		apply_setting({" ", "\\", "\"", ","}, 3'd4, {"x", ",", "\"", " "}, 3'd3);
		run_random_phase();
		drain_results();

		// Fully random setting
		apply_setting($urandom, 3'($urandom_range(4)), $urandom, 3'($urandom_range(4)));
		run_random_phase();
		drain_results();

		$display("Covered %0d requests in %0d strings, %0d results checked, %0d register settings.",
			requests_seen, strings_seen, results_seen, settings_used);
		if (fail_count == 0)
			$display("[quoted_field_tokenizer] OK");
		else
			$display("[quoted_field_tokenizer] ERROR");
		$finish;
	end

endmodule
